### rtl/mlk_pkg.sv
// ----------------------------------------------------------------------------
// mlk_pkg
// Shared types, constants and the Morse letter table for the line keyer.
// ----------------------------------------------------------------------------
package mlk_pkg;

    localparam int LINE_DEPTH = 128;

    localparam logic [7:0]  CR_BYTE         = 8'd13;
    localparam logic [7:0]  LETTER_FIRST    = 8'd65;
    localparam logic [7:0]  LETTER_LAST     = 8'd90;
    localparam logic [15:0] DOT_TICKS_RST   = 16'd200;
    localparam logic [15:0] DASH_TICKS_RST  = 16'd1000;
    localparam logic [15:0] GAP_TICKS_RST   = 16'd200;
    localparam int          CFG_IDX_W       = 2;
    localparam int          CFG_DATA_W      = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOT_TICKS  = 2'd0,
        CFG_DASH_TICKS = 2'd1,
        CFG_GAP_TICKS  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EL_NONE = 2'd0,
        EL_DOT  = 2'd1,
        EL_DASH = 2'd2
    } t_element;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       led_on;
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       line_end;
        logic       not_found;
        logic       dropped;
        logic       busy_res;
    } t_out_item;

    // Four elements per letter, element 0 in bits [1:0]; letters A..Z.
    localparam logic [7:0] LETTER_CODES [26] = '{
        {EL_NONE, EL_NONE, EL_DASH, EL_DOT },   // A
        {EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH},   // B
        {EL_DOT,  EL_DASH, EL_DOT,  EL_DASH},   // C
        {EL_NONE, EL_DOT,  EL_DOT,  EL_DASH},   // D
        {EL_NONE, EL_NONE, EL_NONE, EL_DOT },   // E
        {EL_DOT,  EL_DASH, EL_DOT,  EL_DOT },   // F
        {EL_NONE, EL_DOT,  EL_DASH, EL_DASH},   // G
        {EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT },   // H
        {EL_NONE, EL_NONE, EL_DOT,  EL_DOT },   // I
        {EL_DASH, EL_DASH, EL_DASH, EL_DOT },   // J
        {EL_NONE, EL_DASH, EL_DOT,  EL_DASH},   // K
        {EL_DOT,  EL_DOT,  EL_DASH, EL_DOT },   // L
        {EL_NONE, EL_NONE, EL_DASH, EL_DASH},   // M
        {EL_NONE, EL_NONE, EL_DOT,  EL_DASH},   // N
        {EL_NONE, EL_DASH, EL_DASH, EL_DASH},   // O
        {EL_DOT,  EL_DASH, EL_DASH, EL_DOT },   // P
        {EL_DASH, EL_DOT,  EL_DASH, EL_DASH},   // Q
        {EL_NONE, EL_DOT,  EL_DASH, EL_DOT },   // R
        {EL_NONE, EL_DOT,  EL_DOT,  EL_DOT },   // S
        {EL_NONE, EL_NONE, EL_NONE, EL_DASH},   // T
        {EL_NONE, EL_DASH, EL_DOT,  EL_DOT },   // U
        {EL_DASH, EL_DOT,  EL_DOT,  EL_DOT },   // V
        {EL_NONE, EL_DASH, EL_DASH, EL_DOT },   // W
        {EL_DASH, EL_DOT,  EL_DOT,  EL_DASH},   // X
        {EL_DASH, EL_DASH, EL_DOT,  EL_DASH},   // Y
        {EL_DOT,  EL_DOT,  EL_DASH, EL_DASH}    // Z
    };

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= LETTER_FIRST) && (c <= LETTER_LAST);
    endfunction

    // Element codes of a byte; all zero for a byte that is no letter.
    function automatic logic [7:0] letter_code(input logic [7:0] c);
        logic [7:0] idx;
        idx = c - LETTER_FIRST;
        if (is_letter(c)) begin
            return LETTER_CODES[idx[4:0]];
        end
        return 8'd0;
    endfunction

endpackage

### rtl/mlk_line_mem.sv
// ----------------------------------------------------------------------------
// mlk_line_mem
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mlk_line_mem #(
    parameter int LINE_DEPTH = mlk_pkg::LINE_DEPTH,
    parameter int ADDR_W     = $clog2(LINE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] mem [LINE_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mlk_ctrl.sv
// ----------------------------------------------------------------------------
// mlk_ctrl
// Line collection and playback sequencer; builds one result per transaction.
// ----------------------------------------------------------------------------
module mlk_ctrl #(
    parameter int LINE_DEPTH = mlk_pkg::LINE_DEPTH,
    parameter int ADDR_W     = $clog2(LINE_DEPTH),
    parameter int CNT_W      = $clog2(LINE_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mlk_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mlk_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_acc,
    input  mlk_pkg::t_in_item             i_item,
    input  logic [7:0]                    i_rd_data,
    output logic                          o_mem_we,
    output logic [ADDR_W-1:0]             o_mem_waddr,
    output logic [7:0]                    o_mem_wdata,
    output logic [ADDR_W-1:0]             o_mem_raddr,
    output mlk_pkg::t_out_item            o_result
);

    logic [15:0]      r_dot_ticks, r_dash_ticks, r_gap_ticks;
    logic [CNT_W-1:0] r_stored_cnt, n_stored_cnt;
    logic [CNT_W-1:0] r_line_len, n_line_len;
    logic [CNT_W-1:0] r_play_pos, n_play_pos;
    logic [2:0]       r_elem_pos, n_elem_pos;
    logic             r_playing, n_playing;
    logic             r_in_gap, n_in_gap;
    logic [15:0]      r_ticks, n_ticks;
    logic             r_led, n_led;

    logic [7:0]       code;
    logic [2:0]       elem_next;
    logic [1:0]       elem_code;
    logic [15:0]      tick_dec;
    logic [CNT_W-1:0] pos_next;
    logic             do_start, do_next, do_end;
    logic [1:0]       start_code;
    logic [15:0]      start_len;
    mlk_pkg::t_out_item res;

    always_comb begin
        code      = mlk_pkg::letter_code(i_rd_data);
        elem_next = r_elem_pos + 3'd1;
        elem_code = code[2*elem_next[1:0] +: 2];
        tick_dec  = r_ticks - 16'd1;
        pos_next  = r_play_pos + CNT_W'(1);

        n_stored_cnt = r_stored_cnt;
        n_line_len   = r_line_len;
        n_play_pos   = r_play_pos;
        n_elem_pos   = r_elem_pos;
        n_playing    = r_playing;
        n_in_gap     = r_in_gap;
        n_ticks      = r_ticks;
        n_led        = r_led;
        do_start     = 1'b0;
        do_next      = 1'b0;
        do_end       = 1'b0;
        start_code   = code[1:0];
        o_mem_we     = 1'b0;
        res          = '0;

        if (i_acc) begin
            if (i_item.cmd == mlk_pkg::CMD_BYTE) begin
                if (r_playing) begin
                    res.dropped = 1'b1;
                end else begin
                    if (r_stored_cnt == '0) begin
                        n_led = 1'b0;
                    end
                    if (i_item.rx_byte != mlk_pkg::CR_BYTE) begin
                        if (r_stored_cnt < CNT_W'(LINE_DEPTH)) begin
                            o_mem_we       = 1'b1;
                            n_stored_cnt   = r_stored_cnt + CNT_W'(1);
                            res.echo_valid = 1'b1;
                            res.echo_byte  = i_item.rx_byte;
                        end else begin
                            res.dropped = 1'b1;
                        end
                    end else begin
                        res.echo_valid = 1'b1;
                        res.echo_byte  = mlk_pkg::CR_BYTE;
                        res.line_end   = 1'b1;
                        n_line_len     = r_stored_cnt;
                        n_stored_cnt   = '0;
                        n_play_pos     = '0;
                        n_elem_pos     = '0;
                        n_in_gap       = 1'b0;
                        n_ticks        = '0;
                        n_playing      = (r_stored_cnt != '0);
                    end
                end
            end else if (r_playing) begin
                if (r_ticks == '0) begin
                    // Fetch: the prefetched byte is already in the read register.
                    if (mlk_pkg::is_letter(i_rd_data)) begin
                        n_elem_pos = '0;
                        do_start   = 1'b1;
                    end else begin
                        res.not_found = 1'b1;
                        do_next       = 1'b1;
                    end
                end else begin
                    n_ticks = tick_dec;
                    if (tick_dec == '0) begin
                        if (!r_in_gap) begin
                            n_led = 1'b0;
                            if (r_gap_ticks != '0) begin
                                n_in_gap = 1'b1;
                                n_ticks  = r_gap_ticks;
                            end else begin
                                do_end = 1'b1;
                            end
                        end else begin
                            do_end = 1'b1;
                        end
                    end
                end
            end
        end

        if (do_end) begin
            if (mlk_pkg::is_letter(i_rd_data) && elem_next < 3'd4 && elem_code != '0) begin
                n_elem_pos = elem_next;
                start_code = elem_code;
                do_start   = 1'b1;
            end else begin
                do_next = 1'b1;
            end
        end

        start_len = (start_code == mlk_pkg::EL_DASH) ? r_dash_ticks : r_dot_ticks;
        if (do_start) begin
            n_led    = 1'b1;
            n_in_gap = 1'b0;
            n_ticks  = (start_len != '0) ? start_len : 16'd1;
        end

        if (do_next) begin
            n_led      = 1'b0;
            n_elem_pos = '0;
            n_in_gap   = 1'b0;
            n_ticks    = '0;
            n_play_pos = pos_next;
            if (pos_next >= r_line_len) begin
                n_playing  = 1'b0;
                n_play_pos = '0;
            end
        end

        res.led_on   = n_led;
        res.busy_res = n_playing;
    end

    assign o_mem_waddr = r_stored_cnt[ADDR_W-1:0];
    assign o_mem_wdata = i_item.rx_byte;
    assign o_mem_raddr = n_play_pos[ADDR_W-1:0];
    assign o_result    = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_ticks  <= mlk_pkg::DOT_TICKS_RST;
            r_dash_ticks <= mlk_pkg::DASH_TICKS_RST;
            r_gap_ticks  <= mlk_pkg::GAP_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mlk_pkg::CFG_DOT_TICKS:  r_dot_ticks  <= i_cfg_data;
                mlk_pkg::CFG_DASH_TICKS: r_dash_ticks <= i_cfg_data;
                mlk_pkg::CFG_GAP_TICKS:  r_gap_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored_cnt <= '0;
            r_line_len   <= '0;
            r_play_pos   <= '0;
            r_elem_pos   <= '0;
            r_playing    <= 1'b0;
            r_in_gap     <= 1'b0;
            r_ticks      <= '0;
            r_led        <= 1'b0;
        end else begin
            r_stored_cnt <= n_stored_cnt;
            r_line_len   <= n_line_len;
            r_play_pos   <= n_play_pos;
            r_elem_pos   <= n_elem_pos;
            r_playing    <= n_playing;
            r_in_gap     <= n_in_gap;
            r_ticks      <= n_ticks;
            r_led        <= n_led;
        end
    end

    a_play_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> (r_line_len != '0) && (r_play_pos < r_line_len))
        else $error("play position outside the line");

    a_play_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> (r_stored_cnt == '0))
        else $error("bytes stored while playing");

    a_no_write_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> !r_playing)
        else $error("line store written during playback");

    a_elem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elem_pos < 3'd4)
        else $error("element position out of range");

endmodule

### rtl/mlk_out_buf.sv
// ----------------------------------------------------------------------------
// mlk_out_buf
// Output register with a skid stage so the input side keeps moving.
// ----------------------------------------------------------------------------
module mlk_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mlk_pkg::t_out_item i_data,
    output logic               o_full,
    output logic               o_out_valid,
    output mlk_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    logic               r_out_valid, r_skid_valid;
    mlk_pkg::t_out_item r_out_data, r_skid_data;
    logic               pop;

    assign pop = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds data ahead of an empty output register");

endmodule

### rtl/morse_line_keyer.sv
// ----------------------------------------------------------------------------
// morse_line_keyer
// Collects a text line, then keys its letters as Morse code on an LED.
// ----------------------------------------------------------------------------
// Results go to the output register, or to the skid stage while it
//   is held. One transaction per cycle unless the input is stalled; each takes
//   one store access and one counter update, and the next byte is prefetched.
// Reset: synchronous, active low; clears all control state and restores the
//   tick registers. The line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module morse_line_keyer #(
    parameter int LINE_DEPTH = mlk_pkg::LINE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [mlk_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mlk_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel: received bytes and ticks
    input  logic                           i_in_valid,
    input  mlk_pkg::t_in_item              i_in_data,
    output logic                           o_in_stall,
    // output channel: one result per input transaction
    output logic                           o_out_valid,
    output mlk_pkg::t_out_item             o_out_data,
    input  logic                           i_out_stall
);

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int CNT_W  = $clog2(LINE_DEPTH + 1);

    logic               acc;
    logic               buf_full;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [7:0]         mem_wdata, mem_rdata;
    mlk_pkg::t_out_item result;

    // Stall the input only when both output register and skid hold results.
    assign o_in_stall = buf_full;
    assign acc        = i_in_valid && !buf_full;

    // Line store. The read address always follows the next play position,
    // so the read register always holds the byte at the current play position.
    // Writes happen only while idle and reads matter only while playing,
    // so the two ports never touch the same entry in a way that matters.
    mlk_line_mem #(
        .LINE_DEPTH (LINE_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Sequencer: gathers the line, paces the elements, forms the result.
    mlk_ctrl #(
        .LINE_DEPTH (LINE_DEPTH),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (acc),
        .i_item      (i_in_data),
        .i_rd_data   (mem_rdata),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .o_result    (result)
    );

    // Hold results until the receiver takes them.
    mlk_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (acc),
        .i_data      (result),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
